// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== src/re_pkg.sv =====
// ----------------------------------------------------------------------------
// Reprojection error package
// Widths, register indexes and transaction types shared by the front, back and top modules.
// ----------------------------------------------------------------------------
package re_pkg;

    localparam int COORD_W   = 32;                    // input coordinate width
    localparam int FRAC_BITS = 16;                    // fraction bits of Q16.16
    localparam int COEF_W    = 32;                    // one matrix coefficient
    localparam int CFG_DATA_W = 2 * COEF_W;           // one register
    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = COEF_W + COORD_W;      // coefficient times coordinate
    localparam int ROW_W     = PROD_W + 2;            // sum of three products and offset
    localparam int MAG_W     = ROW_W - 1;             // magnitude of a row sum
    localparam int NUM_W     = MAG_W + FRAC_BITS;     // scaled dividend
    localparam int QUO_W     = 34;                    // quotient bits kept exactly
    localparam int DIV_W     = MAG_W + QUO_W;         // divisor shifted to the top step
    localparam int DIFF_W    = QUO_W + 2;             // observed minus projected
    localparam int OUT_W     = 64;
    localparam int HALF_W    = OUT_W / 2;             // largest difference magnitude width

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_C01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_C23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_C01 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_C23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_C01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_C23 = 3'd5;

    typedef struct packed {
        logic signed [COORD_W-1:0] world_x;
        logic signed [COORD_W-1:0] world_y;
        logic signed [COORD_W-1:0] world_z;
        logic signed [COORD_W-1:0] image_u;
        logic signed [COORD_W-1:0] image_v;
    } t_re_in;

    typedef struct packed {
        logic [OUT_W-1:0] squared_error;
        logic             behind_camera;
        logic             saturated;
    } t_re_out;

    // classified item handed from projection to division
    typedef struct packed {
        logic                      behind;
        logic                      neg_x;
        logic                      neg_y;
        logic                      ov_x;
        logic                      ov_y;
        logic [NUM_W-1:0]          num_x;
        logic [NUM_W-1:0]          num_y;
        logic [MAG_W-1:0]          den;
        logic signed [COORD_W-1:0] obs_u;
        logic signed [COORD_W-1:0] obs_v;
    } t_re_mid;

endpackage

// ===== src/re_fifo.sv =====
// ----------------------------------------------------------------------------
// Small synchronous queue
// Register-based FIFO with power-of-two depth and combinational read data.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module re_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);

    localparam int AW = $clog2(DEPTH);

    T                r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [AW:0]     r_count;
    logic            w_do_push;
    logic            w_do_pop;

    assign o_full    = (r_count == (AW+1)'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) r_wr <= r_wr + 1'b1;
            if (w_do_pop)  r_rd <= r_rd + 1'b1;
            if (w_do_push && !w_do_pop) r_count <= r_count + 1'b1;
            else if (!w_do_push && w_do_pop) r_count <= r_count - 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) r_mem[r_wr] <= i_data;
    end

    `ASSERT_CLK(a_count_range, i_clk, i_rst_n, r_count <= (AW+1)'(DEPTH), "fifo overfilled")
    `ASSERT_CLK(a_push_only, i_clk, i_rst_n, (w_do_push && !w_do_pop) |=> (r_count == $past(r_count) + 1'b1), "fifo count lost a push")
    `ASSERT_CLK(a_ptr_gap, i_clk, i_rst_n, (r_count == (AW+1)'(DEPTH)) || (r_count == '0) || (r_wr != r_rd), "fifo pointers out of step")

endmodule

// ===== src/re_front.sv =====
// ----------------------------------------------------------------------------
// Reprojection front end
// Holds the projection matrix, forms the three row sums and classifies each
// point: behind camera, quotient sign, scaled dividend and overflow.
// ----------------------------------------------------------------------------
module re_front import re_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_push,
    output logic                  o_full,
    input  t_re_in                i_item,
    output logic                  o_vld,
    output t_re_mid               o_item,
    input  logic                  i_ready
);

    localparam int NSTG = 5;

    logic [CFG_DATA_W-1:0]     r_proj [NUM_REGS];
    logic signed [COEF_W-1:0]  w_coef [3][4];
    logic signed [COORD_W-1:0] w_pt [3];
    logic signed [PROD_W-1:0]  w_prod [3][3];

    logic [NSTG-1:0]           r_vld;
    logic signed [COORD_W-1:0] r_obs_u [NSTG-1];
    logic signed [COORD_W-1:0] r_obs_v [NSTG-1];
    logic signed [PROD_W-1:0]  r_prod [3][3];
    logic signed [COEF_W-1:0]  r_cst [3];
    logic signed [ROW_W-1:0]   r_sa [3];
    logic signed [ROW_W-1:0]   r_sb [3];
    logic signed [ROW_W-1:0]   r_row [3];
    logic signed [ROW_W-1:0]   w_nrow [2];
    logic                      r_behind4;
    logic [1:0]                r_neg4;
    logic [MAG_W-1:0]          r_mag4 [2];
    logic [MAG_W-1:0]          r_den4;
    logic [DIV_W-1:0]          w_lim;
    logic [DIV_W-1:0]          w_numx_ext;
    logic [DIV_W-1:0]          w_numy_ext;
    logic                      w_adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) r_proj[i] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROW0_C01: r_proj[0] <= i_cfg_data;
                REG_ROW0_C23: r_proj[1] <= i_cfg_data;
                REG_ROW1_C01: r_proj[2] <= i_cfg_data;
                REG_ROW1_C23: r_proj[3] <= i_cfg_data;
                REG_ROW2_C01: r_proj[4] <= i_cfg_data;
                REG_ROW2_C23: r_proj[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // coefficient unpacking, even column in the upper half
    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 4; c++) begin : g_col
            if (c % 2 == 0) begin : g_even
                assign w_coef[r][c] = r_proj[2*r + c/2][CFG_DATA_W-1:COEF_W];
            end else begin : g_odd
                assign w_coef[r][c] = r_proj[2*r + c/2][COEF_W-1:0];
            end
        end
        for (genvar c = 0; c < 3; c++) begin : g_mul
            assign w_prod[r][c] = w_coef[r][c] * w_pt[c];
        end
    end

    assign w_pt[0] = i_item.world_x;
    assign w_pt[1] = i_item.world_y;
    assign w_pt[2] = i_item.world_z;

    assign w_nrow[0] = -r_row[0];
    assign w_nrow[1] = -r_row[1];

    // overflow bound: quotient would need more than QUO_W bits
    assign w_lim      = {r_den4, {QUO_W{1'b0}}};
    assign w_numx_ext = {{(DIV_W-NUM_W){1'b0}}, r_mag4[0], {FRAC_BITS{1'b0}}};
    assign w_numy_ext = {{(DIV_W-NUM_W){1'b0}}, r_mag4[1], {FRAC_BITS{1'b0}}};

    assign w_adv  = !r_vld[NSTG-1] || i_ready;
    assign o_full = !w_adv;
    assign o_vld  = r_vld[NSTG-1];

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_push};
        end
    end

    // projection and classification pipeline
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // products
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) r_prod[r][c] <= w_prod[r][c];
                r_cst[r] <= w_coef[r][3];
            end
            r_obs_u[0] <= i_item.image_u;
            r_obs_v[0] <= i_item.image_v;
            // partial sums
            for (int r = 0; r < 3; r++) begin
                r_sa[r] <= {{(ROW_W-PROD_W){r_prod[r][0][PROD_W-1]}}, r_prod[r][0]}
                         + {{(ROW_W-PROD_W){r_prod[r][1][PROD_W-1]}}, r_prod[r][1]};
                r_sb[r] <= {{(ROW_W-PROD_W){r_prod[r][2][PROD_W-1]}}, r_prod[r][2]}
                         + {{(ROW_W-COEF_W-FRAC_BITS){r_cst[r][COEF_W-1]}}, r_cst[r],
                            {FRAC_BITS{1'b0}}};
            end
            // row sums
            for (int r = 0; r < 3; r++) r_row[r] <= r_sa[r] + r_sb[r];
            for (int k = 1; k < NSTG-1; k++) begin
                r_obs_u[k] <= r_obs_u[k-1];
                r_obs_v[k] <= r_obs_v[k-1];
            end
            // signs and magnitudes
            r_behind4 <= r_row[2][ROW_W-1] || (r_row[2] == '0);
            for (int r = 0; r < 2; r++) begin
                r_neg4[r] <= r_row[r][ROW_W-1];
                r_mag4[r] <= r_row[r][ROW_W-1] ? w_nrow[r][MAG_W-1:0] : r_row[r][MAG_W-1:0];
            end
            r_den4 <= r_row[2][MAG_W-1:0];
            // classified item
            o_item.behind <= r_behind4;
            o_item.neg_x  <= r_neg4[0];
            o_item.neg_y  <= r_neg4[1];
            o_item.ov_x   <= (w_numx_ext >= w_lim);
            o_item.ov_y   <= (w_numy_ext >= w_lim);
            o_item.num_x  <= {r_mag4[0], {FRAC_BITS{1'b0}}};
            o_item.num_y  <= {r_mag4[1], {FRAC_BITS{1'b0}}};
            o_item.den    <= r_den4;
            o_item.obs_u  <= r_obs_u[NSTG-2];
            o_item.obs_v  <= r_obs_v[NSTG-2];
        end
    end

endmodule

// ===== src/re_back.sv =====
// ----------------------------------------------------------------------------
// Reprojection back end
// Pipelined restoring division of both image coordinates, one quotient bit
// per stage, then difference, squares and saturating sum.
// ----------------------------------------------------------------------------
module re_back import re_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_vld,
    output logic    o_pop,
    input  t_re_mid i_item,
    output logic    o_vld,
    output t_re_out o_item,
    input  logic    i_ready
);

    localparam int NPOST = 4;

    logic [QUO_W-1:0]  r_dvld;
    t_re_mid           r_ctl [QUO_W];
    logic [NUM_W-1:0]  r_rem_x [QUO_W];
    logic [NUM_W-1:0]  r_rem_y [QUO_W];
    logic [QUO_W-1:0]  r_q_x [QUO_W];
    logic [QUO_W-1:0]  r_q_y [QUO_W];
    logic [NUM_W-1:0]  w_rem_x_n [QUO_W];
    logic [NUM_W-1:0]  w_rem_y_n [QUO_W];
    logic [QUO_W-1:0]  w_q_x_n [QUO_W];
    logic [QUO_W-1:0]  w_q_y_n [QUO_W];

    logic [NPOST-1:0]          r_pvld;
    logic                      r_beh [NPOST-1];
    logic                      r_big [NPOST-1];
    logic signed [DIFF_W-1:0]  r_dx;
    logic signed [DIFF_W-1:0]  r_dy;
    logic [HALF_W-1:0]         r_mx;
    logic [HALF_W-1:0]         r_my;
    logic [OUT_W-1:0]          r_sqx;
    logic [OUT_W-1:0]          r_sqy;
    logic signed [DIFF_W-1:0]  w_ou;
    logic signed [DIFF_W-1:0]  w_ov;
    logic signed [DIFF_W-1:0]  w_qx;
    logic signed [DIFF_W-1:0]  w_qy;
    logic [DIFF_W-1:0]         w_ax;
    logic [DIFF_W-1:0]         w_ay;
    logic [OUT_W:0]            w_sum;
    logic                      w_adv;

    assign w_adv = !r_pvld[NPOST-1] || i_ready;
    assign o_pop = w_adv && i_vld;
    assign o_vld = r_pvld[NPOST-1];

    // one quotient bit per stage, most significant first
    for (genvar i = 0; i < QUO_W; i++) begin : g_div
        logic [DIV_W-1:0] w_dk;
        logic [DIV_W-1:0] w_rx;
        logic [DIV_W-1:0] w_ry;
        logic [DIV_W-1:0] w_tx;
        logic [DIV_W-1:0] w_ty;
        logic [QUO_W-1:0] w_qxi;
        logic [QUO_W-1:0] w_qyi;
        logic             w_gx;
        logic             w_gy;
        if (i == 0) begin : g_first
            assign w_dk  = {i_item.den, {QUO_W{1'b0}}} >> 1;
            assign w_rx  = {{(DIV_W-NUM_W){1'b0}}, i_item.num_x};
            assign w_ry  = {{(DIV_W-NUM_W){1'b0}}, i_item.num_y};
            assign w_qxi = '0;
            assign w_qyi = '0;
        end else begin : g_next
            assign w_dk  = {r_ctl[i-1].den, {QUO_W{1'b0}}} >> (i + 1);
            assign w_rx  = {{(DIV_W-NUM_W){1'b0}}, r_rem_x[i-1]};
            assign w_ry  = {{(DIV_W-NUM_W){1'b0}}, r_rem_y[i-1]};
            assign w_qxi = r_q_x[i-1];
            assign w_qyi = r_q_y[i-1];
        end
        assign w_gx = (w_rx >= w_dk);
        assign w_gy = (w_ry >= w_dk);
        assign w_tx = w_rx - w_dk;
        assign w_ty = w_ry - w_dk;
        always_comb begin
            w_rem_x_n[i] = w_gx ? w_tx[NUM_W-1:0] : w_rx[NUM_W-1:0];
            w_rem_y_n[i] = w_gy ? w_ty[NUM_W-1:0] : w_ry[NUM_W-1:0];
            w_q_x_n[i]   = w_qxi;
            w_q_y_n[i]   = w_qyi;
            w_q_x_n[i][QUO_W-1-i] = w_gx;
            w_q_y_n[i][QUO_W-1-i] = w_gy;
        end
    end

    // valids of division and post stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld <= '0;
            r_pvld <= '0;
        end else if (w_adv) begin
            r_dvld <= {r_dvld[QUO_W-2:0], i_vld};
            r_pvld <= {r_pvld[NPOST-2:0], r_dvld[QUO_W-1]};
        end
    end

    // division stages
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < QUO_W; i++) begin
                r_rem_x[i] <= w_rem_x_n[i];
                r_rem_y[i] <= w_rem_y_n[i];
                r_q_x[i]   <= w_q_x_n[i];
                r_q_y[i]   <= w_q_y_n[i];
            end
            r_ctl[0] <= i_item;
            for (int i = 1; i < QUO_W; i++) r_ctl[i] <= r_ctl[i-1];
        end
    end

    assign w_ou = {{(DIFF_W-COORD_W){r_ctl[QUO_W-1].obs_u[COORD_W-1]}}, r_ctl[QUO_W-1].obs_u};
    assign w_ov = {{(DIFF_W-COORD_W){r_ctl[QUO_W-1].obs_v[COORD_W-1]}}, r_ctl[QUO_W-1].obs_v};
    assign w_qx = {2'b00, r_q_x[QUO_W-1]};
    assign w_qy = {2'b00, r_q_y[QUO_W-1]};
    assign w_ax = r_dx[DIFF_W-1] ? DIFF_W'(-r_dx) : DIFF_W'(r_dx);
    assign w_ay = r_dy[DIFF_W-1] ? DIFF_W'(-r_dy) : DIFF_W'(r_dy);
    assign w_sum = {1'b0, r_sqx} + {1'b0, r_sqy};

    // difference, magnitude, squares and sum
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dx   <= r_ctl[QUO_W-1].neg_x ? (w_ou + w_qx) : (w_ou - w_qx);
            r_dy   <= r_ctl[QUO_W-1].neg_y ? (w_ov + w_qy) : (w_ov - w_qy);
            r_beh[0] <= r_ctl[QUO_W-1].behind;
            r_big[0] <= r_ctl[QUO_W-1].ov_x || r_ctl[QUO_W-1].ov_y;

            r_mx     <= w_ax[HALF_W-1:0];
            r_my     <= w_ay[HALF_W-1:0];
            r_beh[1] <= r_beh[0];
            r_big[1] <= r_big[0] || (w_ax[DIFF_W-1:HALF_W] != '0)
                                 || (w_ay[DIFF_W-1:HALF_W] != '0);

            r_sqx    <= r_mx * r_mx;
            r_sqy    <= r_my * r_my;
            r_beh[2] <= r_beh[1];
            r_big[2] <= r_big[1];

            if (r_beh[2]) begin
                o_item.squared_error <= '1;
                o_item.behind_camera <= 1'b1;
                o_item.saturated     <= 1'b0;
            end else if (r_big[2] || w_sum[OUT_W]) begin
                o_item.squared_error <= '1;
                o_item.behind_camera <= 1'b0;
                o_item.saturated     <= 1'b1;
            end else begin
                o_item.squared_error <= w_sum[OUT_W-1:0];
                o_item.behind_camera <= 1'b0;
                o_item.saturated     <= 1'b0;
            end
        end
    end

endmodule

// ===== src/reprojection_error.sv =====
// ----------------------------------------------------------------------------
// Squared reprojection error
// Pinhole 3x4 projection of a world point and squared distance to its
// observed image point, in signed Q16.16 in and unsigned Q32.32 out.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock while full is low and returns one result
// per transaction, in order. From push to the result at the queue head an item
// passes five projection stages, the middle queue, a 34-stage pipelined divider
// that yields one quotient bit per stage for both image coordinates, four
// stages of difference, square and sum, and the result queue. The user must
// write matrix registers through the cfg port only while no transaction is in
// flight; the block itself does not enforce it. Depth not greater than zero
// gives all ones with behind_camera set; a distance too large for Q32.32 gives
// all ones with saturated set.
`include "assert_macros.svh"

module reprojection_error import re_pkg::*; #(
    parameter int MID_QUEUE_DEPTH = MID_DEPTH,
    parameter int OUT_QUEUE_DEPTH = OUT_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  t_re_in                i_item,
    output logic                  empty,
    input  logic                  pop,
    output t_re_out               o_item
);

    logic    w_f_vld;
    t_re_mid w_f_item;
    logic    w_mid_full;
    logic    w_mid_empty;
    t_re_mid w_mid_item;
    logic    w_mid_pop;
    logic    w_b_vld;
    t_re_out w_b_item;
    logic    w_out_full;

    // projection and classification
    re_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_vld       (w_f_vld),
        .o_item      (w_f_item),
        .i_ready     (!w_mid_full)
    );

    // decoupling queue
    re_fifo #(.T(t_re_mid), .DEPTH(MID_QUEUE_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_vld),
        .i_data  (w_f_item),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_item),
        .o_empty (w_mid_empty)
    );

    // division and error
    re_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (!w_mid_empty),
        .o_pop   (w_mid_pop),
        .i_item  (w_mid_item),
        .o_vld   (w_b_vld),
        .o_item  (w_b_item),
        .i_ready (!w_out_full)
    );

    // result queue
    re_fifo #(.T(t_re_out), .DEPTH(OUT_QUEUE_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_b_vld),
        .i_data  (w_b_item),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (o_item),
        .o_empty (empty)
    );

    `ASSERT_CLK(a_flags_excl, i_clk, i_rst_n, !empty |-> !(o_item.behind_camera && o_item.saturated), "both result flags set")
    `ASSERT_CLK(a_flag_ones, i_clk, i_rst_n, (!empty && (o_item.behind_camera || o_item.saturated)) |-> (o_item.squared_error == '1), "flagged result not all ones")
    `ASSERT_CLK(a_back_push, i_clk, i_rst_n, (w_b_vld && w_out_full) |=> w_b_vld, "back end dropped a result")

endmodule
